@@ design/vhfp_pkg.sv @@
// Shared types, phase codes and field widths for the VPS header field parser.
package vhfp_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int VALUE_W       = 48;
    localparam int CNT_W         = 6;
    localparam int RESERVED_W    = 16;
    localparam int COMPAT_W      = 32;
    localparam int ELEM_CODE_MAX = 19;

    // Parse phases; codes 0..19 are also the emitted element codes.
    typedef enum logic [4:0] {
        PH_VPS_ID        = 5'd0,
        PH_BASE_INTERNAL = 5'd1,
        PH_BASE_AVAIL    = 5'd2,
        PH_MAX_LAYERS    = 5'd3,
        PH_MAX_SUB       = 5'd4,
        PH_NESTING       = 5'd5,
        PH_GEN_SPACE     = 5'd6,
        PH_GEN_TIER      = 5'd7,
        PH_GEN_IDC       = 5'd8,
        PH_GEN_COMPAT    = 5'd9,
        PH_GEN_CONSTR    = 5'd10,
        PH_GEN_LEVEL     = 5'd11,
        PH_SUB_PROF_PRES = 5'd12,
        PH_SUB_LVL_PRES  = 5'd13,
        PH_SUB_SPACE     = 5'd14,
        PH_SUB_TIER      = 5'd15,
        PH_SUB_IDC       = 5'd16,
        PH_SUB_COMPAT    = 5'd17,
        PH_SUB_CONSTR    = 5'd18,
        PH_SUB_LEVEL     = 5'd19,
        PH_RESERVED      = 5'd20,
        PH_ALIGN         = 5'd21,
        PH_DONE          = 5'd22
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } t_in_item;

    typedef struct packed {
        logic [4:0]         element_code;
        logic [2:0]         sub_layer_index;
        logic [VALUE_W-1:0] element_value;
        logic               header_done;
        logic               run_last;
    } t_out_item;

    // Byte shifter to field engine.
    typedef struct packed {
        logic bit_valid;
        logic bit_val;
        logic start;
        logic last;
    } t_bit_ctl;

    // Result queue status back to the step gate.
    typedef struct packed {
        logic pend_valid;
        logic load_ok;
    } t_q_status;

    // Bits in each phase; alignment length follows max_sub_layers_minus1.
    function automatic logic [CNT_W-1:0] phase_width(t_phase ph, logic [2:0] raw);
        logic [CNT_W-1:0] w;
        unique case (ph)
            PH_VPS_ID:        w = 6'd4;
            PH_BASE_INTERNAL: w = 6'd1;
            PH_BASE_AVAIL:    w = 6'd1;
            PH_MAX_LAYERS:    w = 6'd6;
            PH_MAX_SUB:       w = 6'd3;
            PH_NESTING:       w = 6'd1;
            PH_GEN_SPACE:     w = 6'd2;
            PH_GEN_TIER:      w = 6'd1;
            PH_GEN_IDC:       w = 6'd5;
            PH_GEN_COMPAT:    w = CNT_W'(COMPAT_W);
            PH_GEN_CONSTR:    w = CNT_W'(VALUE_W);
            PH_GEN_LEVEL:     w = 6'd8;
            PH_SUB_PROF_PRES: w = 6'd1;
            PH_SUB_LVL_PRES:  w = 6'd1;
            PH_SUB_SPACE:     w = 6'd2;
            PH_SUB_TIER:      w = 6'd1;
            PH_SUB_IDC:       w = 6'd5;
            PH_SUB_COMPAT:    w = CNT_W'(COMPAT_W);
            PH_SUB_CONSTR:    w = CNT_W'(VALUE_W);
            PH_SUB_LEVEL:     w = 6'd8;
            PH_RESERVED:      w = CNT_W'(RESERVED_W);
            PH_ALIGN:         w = 6'd16 - {2'b00, raw, 1'b0};
            default:          w = 6'd0;
        endcase
        return w;
    endfunction

endpackage

@@ design/vps_header_field_parser.sv @@
// Top level of the VPS header field parser: byte shifter, field engine, result queue.
//
// Parses a video parameter set RBSP (emulation-prevention bytes already
// stripped) one bit per clock while the bit engine is not stalled, MSB
// first; the byte shifter takes the next byte in the cycle its last bit
// goes. Every syntax element of the VPS prefix and the profile/tier/level
// structure is sent as one transfer when its last bit arrives; the 16
// reserved bits and the alignment bits are consumed silently. A byte may
// produce up to 8 transfers; run_last marks the last of them, so each
// result sits one slot in a pending register until the engine knows
// whether another follows in the same byte. A completed result passes
// from the pending register to the output register that drives
// o_out_valid once it is the last of its byte or another result follows,
// and waits there through any output stall.
// The bit engine stalls whenever the pending slot is full and the output
// register is held by i_out_stall. start_req on a byte restarts the parse
// from that byte; after header_done, bytes are drained and ignored until the
// next start.
module vps_header_field_parser
    import vhfp_pkg::*;
#(
    parameter int SUB_LAYER_SLOTS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_bit_ctl  w_bit;
    t_q_status w_qstat;
    t_out_item w_res;
    logic      w_res_valid;
    logic      w_step;
    logic      w_close;

    // One bit advances whenever the pending slot can make room for a result.
    assign w_step  = w_bit.bit_valid && (!w_qstat.pend_valid || w_qstat.load_ok);
    assign w_close = w_step && w_bit.last;

    vhfp_byte_shifter u_shifter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_step     (w_step),
        .o_bit      (w_bit)
    );

    vhfp_field_engine #(
        .SUB_LAYER_SLOTS (SUB_LAYER_SLOTS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_bit       (w_bit),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    vhfp_result_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .i_close     (w_close),
        .o_status    (w_qstat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // A new result never lands on a pending one that cannot leave.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (!w_qstat.pend_valid || w_qstat.load_ok))
        else $error("result would overwrite a stuck pending slot");

    // The header's final element always closes its run.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.header_done) |-> o_out_data.run_last)
        else $error("header_done without run_last");

    // Internal skip phases never leak out.
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.element_code <= 5'(ELEM_CODE_MAX)))
        else $error("element code out of range");

    // Sub-layer index only on sub-layer elements.
    a_sub_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.element_code < PH_SUB_PROF_PRES))
            |-> (o_out_data.sub_layer_index == 3'd0))
        else $error("sub-layer index set on a general element");

endmodule

@@ design/vhfp_byte_shifter.sv @@
// Input byte register that shifts one bit per cycle when stepped, MSB first.
module vhfp_byte_shifter
    import vhfp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_data,
    input  logic     i_step,
    output t_bit_ctl o_bit
);

    logic [BITS_PER_BYTE-1:0] r_bits, n_bits;
    logic [3:0]               r_left, n_left;
    logic                     r_start, n_start;
    logic                     w_accept;

    // Free when empty, or when the last bit goes this cycle.
    assign o_in_stall = !((r_left == 4'd0) || ((r_left == 4'd1) && i_step));
    assign w_accept   = i_in_valid && !o_in_stall;

    assign o_bit.bit_valid = (r_left != 4'd0);
    assign o_bit.bit_val   = r_bits[BITS_PER_BYTE-1];
    assign o_bit.start     = r_start;
    assign o_bit.last      = (r_left == 4'd1);

    always_comb begin
        n_bits  = r_bits;
        n_left  = r_left;
        n_start = r_start;
        if (i_step) begin
            n_bits  = {r_bits[BITS_PER_BYTE-2:0], 1'b0};
            n_left  = r_left - 4'd1;
            n_start = 1'b0;
        end
        if (w_accept) begin
            n_bits  = i_in_data.data_byte;
            n_left  = 4'(BITS_PER_BYTE);
            n_start = i_in_data.start_req;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
        if (!i_rst_n) begin
            r_left  <= 4'd0;
            r_start <= 1'b0;
        end else begin
            r_left  <= n_left;
            r_start <= n_start;
        end
    end

endmodule

@@ design/vhfp_field_engine.sv @@
// Bit-serial field engine: accumulates bits, tracks the parse phase, emits elements.
module vhfp_field_engine
    import vhfp_pkg::*;
#(
    parameter int SUB_LAYER_SLOTS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_bit_ctl  i_bit,
    output logic      o_res_valid,
    output t_out_item o_res
);

    typedef struct packed {
        t_phase     ph;
        logic [2:0] idx;
    } t_sel;

    logic [VALUE_W-1:0]         r_acc, n_acc, c_acc, w_acc_sh;
    logic [CNT_W-1:0]           r_cnt, n_cnt, c_cnt, w_cnt1;
    t_phase                     r_ph, n_ph, c_ph, w_nx;
    logic [2:0]                 r_sub, n_sub, c_sub, w_ni;
    logic [2:0]                 r_sub_cnt, n_sub_cnt, c_sub_cnt, w_cnt_new;
    logic [2:0]                 r_raw, n_raw, c_raw, w_raw_new;
    logic [SUB_LAYER_SLOTS-1:0] r_pp, n_pp, c_pp, w_pp_upd;
    logic [SUB_LAYER_SLOTS-1:0] r_lp, n_lp, c_lp, w_lp_upd;
    logic                       r_active, n_active, c_active;
    logic                       w_complete, w_done, w_lp_cur;
    logic [3:0]                 w_sub_inc;
    t_sel                       w_sel0, w_sel_next;

    localparam logic [3:0] SLOTS_W = 4'(SUB_LAYER_SLOTS);

    // Lowest sub-layer at or above j that carries a field.
    function automatic t_sel find_sub(logic [3:0] j, logic [SUB_LAYER_SLOTS-1:0] pp,
                                      logic [SUB_LAYER_SLOTS-1:0] lp, logic [2:0] cnt);
        t_sel s;
        s.ph  = PH_DONE;
        s.idx = 3'd0;
        for (int k = SUB_LAYER_SLOTS - 1; k >= 0; k--) begin
            if ((4'(k) >= j) && (3'(k) < cnt) && (pp[k] || lp[k])) begin
                s.ph  = pp[k] ? PH_SUB_SPACE : PH_SUB_LEVEL;
                s.idx = 3'(k);
            end
        end
        return s;
    endfunction

    // A start byte sees the cleared parse from its first bit.
    assign c_acc     = i_bit.start ? '0 : r_acc;
    assign c_cnt     = i_bit.start ? '0 : r_cnt;
    assign c_ph      = i_bit.start ? PH_VPS_ID : r_ph;
    assign c_sub     = i_bit.start ? 3'd0 : r_sub;
    assign c_sub_cnt = i_bit.start ? 3'd0 : r_sub_cnt;
    assign c_raw     = i_bit.start ? 3'd0 : r_raw;
    assign c_pp      = i_bit.start ? '0 : r_pp;
    assign c_lp      = i_bit.start ? '0 : r_lp;
    assign c_active  = i_bit.start | r_active;

    assign w_acc_sh   = {c_acc[VALUE_W-2:0], i_bit.bit_val};
    assign w_cnt1     = c_cnt + 6'd1;
    assign w_complete = c_active && (w_cnt1 >= phase_width(c_ph, c_raw));
    assign w_raw_new  = (c_ph == PH_MAX_SUB) ? w_acc_sh[2:0] : c_raw;
    assign w_cnt_new  = (c_ph != PH_MAX_SUB) ? c_sub_cnt :
                        ({1'b0, w_acc_sh[2:0]} < SLOTS_W) ? w_acc_sh[2:0] : SLOTS_W[2:0];
    assign w_sub_inc  = {1'b0, c_sub} + 4'd1;

    always_comb begin
        w_pp_upd = c_pp;
        w_lp_upd = c_lp;
        w_lp_cur = 1'b0;
        for (int k = 0; k < SUB_LAYER_SLOTS; k++) begin
            if (3'(k) == c_sub) begin
                w_lp_cur = c_lp[k];
                if (c_ph == PH_SUB_PROF_PRES) w_pp_upd[k] = w_acc_sh[0];
                if (c_ph == PH_SUB_LVL_PRES)  w_lp_upd[k] = w_acc_sh[0];
            end
        end
    end

    assign w_sel0     = find_sub(4'd0, w_pp_upd, w_lp_upd, w_cnt_new);
    assign w_sel_next = find_sub(w_sub_inc, w_pp_upd, w_lp_upd, w_cnt_new);

    // Next phase and sub-layer after the element that completes now.
    always_comb begin
        w_nx = PH_DONE;
        w_ni = 3'd0;
        unique case (c_ph)
            PH_VPS_ID, PH_BASE_INTERNAL, PH_BASE_AVAIL, PH_MAX_LAYERS, PH_MAX_SUB,
            PH_GEN_SPACE, PH_GEN_TIER, PH_GEN_IDC, PH_GEN_COMPAT, PH_GEN_CONSTR: begin
                w_nx = t_phase'(c_ph + 5'd1);
            end
            PH_NESTING:  w_nx = PH_RESERVED;
            PH_RESERVED: w_nx = PH_GEN_SPACE;
            PH_GEN_LEVEL: begin
                w_nx = (w_cnt_new != 3'd0) ? PH_SUB_PROF_PRES : PH_DONE;
            end
            PH_SUB_PROF_PRES: begin
                w_nx = PH_SUB_LVL_PRES;
                w_ni = c_sub;
            end
            PH_SUB_LVL_PRES: begin
                if (w_sub_inc < {1'b0, w_cnt_new}) begin
                    w_nx = PH_SUB_PROF_PRES;
                    w_ni = w_sub_inc[2:0];
                end else if (w_raw_new != 3'd0) begin
                    // alignment only matters if a sub-layer field follows it
                    w_nx = (w_sel0.ph == PH_DONE) ? PH_DONE : PH_ALIGN;
                end else begin
                    w_nx = w_sel0.ph;
                    w_ni = w_sel0.idx;
                end
            end
            PH_ALIGN: begin
                w_nx = w_sel0.ph;
                w_ni = w_sel0.idx;
            end
            PH_SUB_SPACE, PH_SUB_TIER, PH_SUB_IDC, PH_SUB_COMPAT: begin
                w_nx = t_phase'(c_ph + 5'd1);
                w_ni = c_sub;
            end
            PH_SUB_CONSTR: begin
                if (w_lp_cur) begin
                    w_nx = PH_SUB_LEVEL;
                    w_ni = c_sub;
                end else begin
                    w_nx = w_sel_next.ph;
                    w_ni = w_sel_next.idx;
                end
            end
            PH_SUB_LEVEL: begin
                w_nx = w_sel_next.ph;
                w_ni = w_sel_next.idx;
            end
            default: w_nx = PH_DONE;
        endcase
    end

    assign w_done = w_complete && (w_nx == PH_DONE);

    // Result outputs.
    always_comb begin
        o_res_valid           = i_step && w_complete && (c_ph < PH_RESERVED);
        o_res.element_code    = c_ph;
        o_res.sub_layer_index = (c_ph >= PH_SUB_PROF_PRES) ? c_sub : 3'd0;
        o_res.element_value   = w_acc_sh;
        o_res.header_done     = w_done;
        o_res.run_last        = w_done || i_bit.last;
    end

    always_comb begin
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_ph      = r_ph;
        n_sub     = r_sub;
        n_sub_cnt = r_sub_cnt;
        n_raw     = r_raw;
        n_pp      = r_pp;
        n_lp      = r_lp;
        n_active  = r_active;
        if (i_step && c_active) begin
            n_acc     = w_acc_sh;
            n_cnt     = w_cnt1;
            n_ph      = c_ph;
            n_sub     = c_sub;
            n_sub_cnt = c_sub_cnt;
            n_raw     = c_raw;
            n_pp      = c_pp;
            n_lp      = c_lp;
            n_active  = 1'b1;
            if (w_complete) begin
                n_acc     = '0;
                n_cnt     = '0;
                n_ph      = w_nx;
                n_sub     = w_ni;
                n_sub_cnt = w_cnt_new;
                n_raw     = w_raw_new;
                n_pp      = w_pp_upd;
                n_lp      = w_lp_upd;
                n_active  = !w_done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_ph      <= PH_VPS_ID;
            r_sub     <= 3'd0;
            r_sub_cnt <= 3'd0;
            r_raw     <= 3'd0;
            r_pp      <= '0;
            r_lp      <= '0;
            r_active  <= 1'b0;
        end else begin
            r_cnt     <= n_cnt;
            r_ph      <= n_ph;
            r_sub     <= n_sub;
            r_sub_cnt <= n_sub_cnt;
            r_raw     <= n_raw;
            r_pp      <= n_pp;
            r_lp      <= n_lp;
            r_active  <= n_active;
        end
    end

endmodule

@@ design/vhfp_result_queue.sv @@
// Pending slot plus output register; closes the run flag at the end of each byte.
module vhfp_result_queue
    import vhfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_res_valid,
    input  t_out_item i_res,
    input  logic      i_close,
    output t_q_status o_status,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_out_item r_pend, n_pend, r_out, n_out;
    logic      r_pend_valid, n_pend_valid, r_out_valid, n_out_valid;
    logic      w_load_ok, w_move;

    assign w_load_ok = !r_out_valid || !i_out_stall;
    // Pending leaves once it is known to be last, or a newer result displaces it.
    assign w_move    = r_pend_valid && w_load_ok && (r_pend.run_last || i_res_valid);

    assign o_status.pend_valid = r_pend_valid;
    assign o_status.load_ok    = w_load_ok;
    assign o_out_valid         = r_out_valid;
    assign o_out_data          = r_out;

    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        if (w_move) begin
            n_out       = r_pend;
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (i_res_valid) begin
            n_pend       = i_res;
            n_pend_valid = 1'b1;
        end else if (w_move) begin
            n_pend_valid = 1'b0;
        end else if (i_close && r_pend_valid) begin
            n_pend.run_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

endmodule

@@ dv/vps_header_field_parser_test.sv @@
// Testbench for the VPS header field parser: random VPS streams checked element by element.
`timescale 1ns / 1ps

module vps_header_field_parser_test
    import vhfp_pkg::*;
();

    localparam int SUB_SLOTS = 8;

    // Tracks the parse of the byte stream and holds the elements it must produce.
    class vps_element_tracker;
        t_out_item   due_elements[$];
        int          errors;

        logic [47:0] shift_bits;
        logic [5:0]  bits_taken;
        t_phase      field;
        logic [2:0]  layer;
        int          layer_limit;
        logic [2:0]  max_sub_m1;
        logic [1:0]  layer_flags [8];   // bit0 profile present, bit1 level present
        bit          parsing;

        function new();
            restart_parse();
            parsing = 1'b0;
            errors  = 0;
        endfunction

        function void restart_parse();
            shift_bits  = '0;
            bits_taken  = '0;
            field       = PH_VPS_ID;
            layer       = '0;
            layer_limit = 0;
            max_sub_m1  = '0;
            foreach (layer_flags[k]) layer_flags[k] = '0;
        endfunction

        // First sub-layer field at or after sub-layer j, or done when none is present.
        function t_phase next_layer_field(input int j, output logic [2:0] idx);
            idx = '0;
            for (int k = j; k < layer_limit && k < 8; k++) begin
                if (layer_flags[k][0]) begin
                    idx = 3'(k);
                    return PH_SUB_SPACE;
                end
                if (layer_flags[k][1]) begin
                    idx = 3'(k);
                    return PH_SUB_LEVEL;
                end
            end
            return PH_DONE;
        endfunction

        // One accepted byte: walk its bits and queue every element it completes.
        function void absorb_byte(input t_in_item it);
            t_out_item  elem;
            t_out_item  held;
            bit         have_held;
            t_phase     nx;
            logic [2:0] ni;
            logic [2:0] scratch;
            logic [5:0] need;
            have_held = 1'b0;
            if (it.start_req) begin
                restart_parse();
                parsing = 1'b1;
            end
            for (int b = 7; b >= 0 && parsing; b--) begin
                shift_bits = {shift_bits[46:0], it.data_byte[b]};
                bits_taken = bits_taken + 6'd1;
                case (field)
                    PH_BASE_INTERNAL, PH_BASE_AVAIL, PH_NESTING, PH_GEN_TIER,
                    PH_SUB_PROF_PRES, PH_SUB_LVL_PRES, PH_SUB_TIER: need = 6'd1;
                    PH_GEN_SPACE, PH_SUB_SPACE:                       need = 6'd2;
                    PH_MAX_SUB:                                       need = 6'd3;
                    PH_VPS_ID:                                        need = 6'd4;
                    PH_GEN_IDC, PH_SUB_IDC:                           need = 6'd5;
                    PH_MAX_LAYERS:                                    need = 6'd6;
                    PH_GEN_LEVEL, PH_SUB_LEVEL:                       need = 6'd8;
                    PH_RESERVED:                                      need = 6'd16;
                    PH_GEN_COMPAT, PH_SUB_COMPAT:                     need = 6'd32;
                    PH_GEN_CONSTR, PH_SUB_CONSTR:                     need = 6'd48;
                    PH_ALIGN: need = 6'(16 - 2 * int'(max_sub_m1));
                    default:                                          need = 6'd0;
                endcase
                if (bits_taken < need) continue;

                case (field)
                    PH_MAX_SUB: begin
                        max_sub_m1  = shift_bits[2:0];
                        layer_limit = (int'(max_sub_m1) < SUB_SLOTS) ? int'(max_sub_m1)
                                                                      : SUB_SLOTS;
                    end
                    PH_SUB_PROF_PRES: layer_flags[layer][0] = shift_bits[0];
                    PH_SUB_LVL_PRES:  layer_flags[layer][1] = shift_bits[0];
                    default: ;
                endcase

                ni = '0;
                case (field)
                    PH_NESTING:   nx = PH_RESERVED;
                    PH_RESERVED:  nx = PH_GEN_SPACE;
                    PH_GEN_LEVEL: nx = (layer_limit > 0) ? PH_SUB_PROF_PRES : PH_DONE;
                    PH_SUB_PROF_PRES: begin
                        nx = PH_SUB_LVL_PRES;
                        ni = layer;
                    end
                    PH_SUB_LVL_PRES: begin
                        if (int'(layer) + 1 < layer_limit) begin
                            nx = PH_SUB_PROF_PRES;
                            ni = layer + 3'd1;
                        end else if (max_sub_m1 != 3'd0) begin
                            nx = PH_ALIGN;
                        end else begin
                            nx = next_layer_field(0, ni);
                        end
                    end
                    PH_ALIGN: nx = next_layer_field(0, ni);
                    PH_SUB_SPACE, PH_SUB_TIER, PH_SUB_IDC, PH_SUB_COMPAT: begin
                        nx = t_phase'(field + 1);
                        ni = layer;
                    end
                    PH_SUB_CONSTR: begin
                        if (layer_flags[layer][1]) begin
                            nx = PH_SUB_LEVEL;
                            ni = layer;
                        end else begin
                            nx = next_layer_field(int'(layer) + 1, ni);
                        end
                    end
                    PH_SUB_LEVEL: nx = next_layer_field(int'(layer) + 1, ni);
                    PH_DONE:      nx = PH_DONE;
                    default:      nx = t_phase'(field + 1);  // prefix and general fields in order
                endcase
                // no sub-layer field after the alignment: header ends at the last flag
                if (nx == PH_ALIGN && next_layer_field(0, scratch) == PH_DONE) nx = PH_DONE;

                if (field < PH_RESERVED) begin
                    if (have_held) due_elements.push_back(held);
                    elem.element_code    = field;
                    elem.sub_layer_index = (field >= PH_SUB_PROF_PRES) ? layer : 3'd0;
                    elem.element_value   = shift_bits;
                    elem.header_done     = (nx == PH_DONE);
                    elem.run_last        = 1'b0;
                    held      = elem;
                    have_held = 1'b1;
                end

                shift_bits = '0;
                bits_taken = '0;
                field      = nx;
                layer      = ni;
                if (nx == PH_DONE) parsing = 1'b0;
            end
            if (have_held) begin
                held.run_last = 1'b1;
                due_elements.push_back(held);
            end
        endfunction

        function void check_element(input t_out_item got);
            t_out_item want;
            if (due_elements.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected element: code %0d layer %0d value %h done %b last %b",
                             got.element_code, got.sub_layer_index, got.element_value,
                             got.header_done, got.run_last);
                return;
            end
            want = due_elements.pop_front();
            if (got.element_code !== want.element_code ||
                got.sub_layer_index !== want.sub_layer_index ||
                got.element_value !== want.element_value ||
                got.header_done !== want.header_done ||
                got.run_last !== want.run_last) begin
                errors++;
                if (errors <= 10)
                    $display("element mismatch: expected code %0d layer %0d value %h done %b last %b",
                             want.element_code, want.sub_layer_index, want.element_value,
                             want.header_done, want.run_last,
                             "; got code %0d layer %0d value %h done %b last %b",
                             got.element_code, got.sub_layer_index, got.element_value,
                             got.header_done, got.run_last);
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    bit        quiet     = 1'b0;   // no idling on either side while set
    int        stall_left = 0;
    int        feed_count = 0;     // bytes the parser actually works on
    bit        hdr_bits[$];        // bit stream of the parameter set being built

    vps_element_tracker tracker = new();

    vps_header_field_parser #(.SUB_LAYER_SLOTS(SUB_SLOTS)) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Receiver: random stall bursts, none while quiet.
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 2);
            out_stall  <= 1'b1;
        end else begin
            out_stall  <= 1'b0;
        end
    end

    // Every element transfer is checked against the oldest pending one.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) tracker.check_element(out_data);
    end

    // One byte transfer, with an optional idle gap in front of it.
    task automatic send_byte(input t_in_item item);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        tracker.absorb_byte(item);
    endtask

    function automatic logic [47:0] field_fill(input bit ones);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return ones ? '1 : r[47:0];
    endfunction

    function automatic void add_field(input int w, input logic [47:0] v);
        for (int k = w - 1; k >= 0; k--) hdr_bits.push_back(v[k]);
    endfunction

    // space, tier, profile idc, compatibility flags, constraint flags
    function automatic void add_profile(input bit ones);
        add_field(2, field_fill(ones));
        add_field(1, field_fill(ones));
        add_field(5, field_fill(ones));
        add_field(32, field_fill(ones));
        add_field(48, field_fill(ones));
    endfunction

    // Builds one parameter set and sends it; cut > 0 truncates it to that many
    // bytes, tail adds bytes without start behind it.
    task automatic send_header(input int raw, input bit ones, input bit bare,
                               input int cut, input int tail);
        bit       prof [8];
        bit       lvl  [8];
        t_in_item item;
        int       nbytes;
        hdr_bits.delete();
        add_field(4, field_fill(ones));        // vps id
        add_field(1, field_fill(ones));        // base layer internal
        add_field(1, field_fill(ones));        // base layer available
        add_field(6, field_fill(ones));        // max layers minus 1
        add_field(3, 48'(raw));                // max sub-layers minus 1
        add_field(1, field_fill(ones));        // temporal id nesting
        add_field(16, field_fill(ones));       // reserved, skipped by the parser
        add_profile(ones);
        add_field(8, field_fill(ones));        // general level
        for (int k = 0; k < raw; k++) begin
            prof[k] = !bare && ($urandom_range(0, 1) == 1);
            lvl[k]  = !bare && ($urandom_range(0, 1) == 1);
            add_field(1, 48'(prof[k]));
            add_field(1, 48'(lvl[k]));
        end
        if (raw > 0) add_field(2 * (8 - raw), field_fill(ones));   // alignment
        for (int k = 0; k < raw; k++) begin
            if (prof[k]) add_profile(ones);
            if (lvl[k]) add_field(8, field_fill(ones));
        end
        while (hdr_bits.size() % 8 != 0) hdr_bits.push_back(1'($urandom_range(0, 1)));

        nbytes = hdr_bits.size() / 8;
        if (cut > 0 && cut < nbytes) nbytes = cut;
        for (int n = 0; n < nbytes; n++) begin
            for (int k = 0; k < 8; k++) item.data_byte[7 - k] = hdr_bits[n * 8 + k];
            item.start_req = (n == 0);
            send_byte(item);
            feed_count++;
        end
        for (int n = 0; n < tail; n++) begin
            item.data_byte = 8'($urandom);
            item.start_req = 1'b0;
            send_byte(item);
        end
    endtask

    initial begin
        t_in_item item;
        int       sel;
        int       raw;
        int       guard;
        bit       first_set;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle bytes: no start seen yet, nothing may come out.
        send_byte('{8'hFF, 1'b0});
        send_byte('{8'h00, 1'b0});
        // A parse that is abandoned: the next set restarts it at the start of the reserved bits.
        send_byte('{8'h00, 1'b1});
        send_byte('{8'hFF, 1'b0});
        // All fields at their maximum, no sub-layers, then trailing bytes
        // that must be ignored after the final element.
        send_header(0, 1'b1, 1'b0, 0, 2);

        // Random part: mostly complete sets with random content and sub-layer
        // layout; some truncated sets, some bare noise with random starts.
        first_set = 1'b1;
        while (feed_count < 80) begin
            sel = $urandom_range(0, 9);
            quiet <= ($urandom_range(0, 3) == 0);
            if (sel == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    item.data_byte = 8'($urandom);
                    item.start_req = ($urandom_range(0, 3) == 0);
                    send_byte(item);
                    feed_count++;
                end
            end else begin
                // first set takes the deepest sub-layer count; most stay small
                if (first_set) raw = 7;
                else if ($urandom_range(0, 3) == 0) raw = $urandom_range(0, 7);
                else raw = $urandom_range(0, 2);
                // a set with no present flags ends before its alignment bits
                send_header(raw, 1'b0, $urandom_range(0, 3) == 0,
                            (sel == 1) ? $urandom_range(1, 15) : 0, $urandom_range(0, 2));
                first_set = 1'b0;
            end
        end

        // Closing set with both sides running flat out.
        quiet <= 1'b1;
        send_header($urandom_range(1, 3), 1'b0, 1'b0, 0, 1);
        in_valid <= 1'b0;

        guard = 0;
        while (tracker.due_elements.size() != 0 && guard < 5000) begin
            @(posedge clk);
            guard++;
        end
        // last byte may still be shifting through the bit engine
        repeat (24) @(posedge clk);

        if (tracker.errors == 0 && tracker.due_elements.size() == 0) begin
            $display("vps_header_field_parser_test: done, clean");
        end else begin
            $display("vps_header_field_parser_test: done, errors");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("vps_header_field_parser_test: done, errors");
        $finish;
    end

endmodule
